[design/touch_adaptive_debounce_assert.svh]
// ============================================================================
// Touch debounce assertion macros
// Concurrent assertion wrappers on clk and rst_n, empty for synthesis.
// ============================================================================
`ifndef TOUCH_ADAPTIVE_DEBOUNCE_ASSERT_SVH
`define TOUCH_ADAPTIVE_DEBOUNCE_ASSERT_SVH

`ifndef SYNTHESIS
// check on every edge once reset is released
`define TAD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every edge, reset included
`define TAD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAD_ASSERT(name, prop, msg)
`define TAD_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[design/tad_pkg.sv]
// ============================================================================
// Touch debounce package
// Shared widths, register codes, reset values and beat types.
// ============================================================================
package tad_pkg;

    // fixed field widths
    localparam int FIELD_BITS    = 12;
    localparam int CFG_BITS      = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_SQ_BITS   = 2 * CFG_BITS;
    localparam int COUNT_BITS    = 8;

    // default coordinate width of the held point
    localparam int COORD_BITS_DEF = 12;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_THR   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STABLE_THR = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM    = 2'd2;

    // register reset values
    localparam logic [CFG_BITS-1:0]    MOVE_THR_RST   = 8'd30;
    localparam logic [CFG_BITS-1:0]    STABLE_THR_RST = 8'd8;
    localparam logic [CFG_BITS-1:0]    CONFIRM_RST    = 8'd3;
    localparam logic [CFG_SQ_BITS-1:0] MOVE_SQ_RST    = 16'd900;
    localparam logic [CFG_SQ_BITS-1:0] STABLE_SQ_RST  = 16'd64;

    // stable count saturates here
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic                  touch_present;
        logic                  point_valid;
        logic [FIELD_BITS-1:0] raw_x;
        logic [FIELD_BITS-1:0] raw_y;
    } sample_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] pos_x;
        logic [FIELD_BITS-1:0] pos_y;
        logic                  pressed;
        logic                  moving;
    } result_t;

    // thresholds as the datapath uses them: squared distances
    typedef struct packed {
        logic [CFG_SQ_BITS-1:0] move_sq;
        logic [CFG_SQ_BITS-1:0] stable_sq;
        logic [CFG_BITS-1:0]    confirm;
    } cfg_t;

endpackage

[design/tad_cfg.sv]
// ============================================================================
// Touch debounce configuration registers
// Holds the squared thresholds and the confirm count.
// ============================================================================
module tad_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tad_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tad_pkg::CFG_BITS-1:0]      cfg_data,
    output tad_pkg::cfg_t                     cfg
);
    import tad_pkg::*;

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic [CFG_SQ_BITS-1:0] data_sq;

    // square the written value once, at write time
    always_comb
    begin
        data_sq  = CFG_SQ_BITS'(cfg_data) * CFG_SQ_BITS'(cfg_data);
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MOVE_THR:   cfg_next.move_sq   = data_sq;
                CFG_STABLE_THR: cfg_next.stable_sq = data_sq;
                CFG_CONFIRM:    cfg_next.confirm   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_sq   <= MOVE_SQ_RST;
            cfg_reg.stable_sq <= STABLE_SQ_RST;
            cfg_reg.confirm   <= CONFIRM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/tad_in_stage.sv]
// ============================================================================
// Touch debounce input register
// Captures one sample beat and holds it until the core takes it.
// ============================================================================
module tad_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  tad_pkg::sample_t sample,
    input  logic             advance,
    output logic             held_valid,
    output tad_pkg::sample_t held_sample
);
    import tad_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    accept;
    sample_t data_reg;

    // take a new beat when empty or when the held one moves on this cycle
    assign sample_stall = valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= sample;
        end
    end

    assign held_valid  = valid_reg;
    assign held_sample = data_reg;

endmodule

[design/tad_core.sv]
// ============================================================================
// Touch debounce core
// Distance test against the held point, state update and result register.
// ============================================================================
`include "touch_adaptive_debounce_assert.svh"

module tad_core #(
    parameter int COORD_BITS = tad_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tad_pkg::cfg_t    cfg,
    input  logic             in_valid,
    input  tad_pkg::sample_t in_sample,
    output logic             advance,
    output logic             result_valid,
    input  logic             result_stall,
    output tad_pkg::result_t result
);
    import tad_pkg::*;

    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int DIST_BITS = SQ_BITS + 1;

    logic [COORD_BITS-1:0] held_x_reg;
    logic [COORD_BITS-1:0] held_x_next;
    logic [COORD_BITS-1:0] held_y_reg;
    logic [COORD_BITS-1:0] held_y_next;
    logic                  held_pressed_reg;
    logic                  held_pressed_next;
    logic                  held_moving_reg;
    logic                  held_moving_next;
    logic [COUNT_BITS-1:0] stable_count_reg;
    logic [COUNT_BITS-1:0] stable_count_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;

    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_BITS-1:0]    sq_x;
    logic [SQ_BITS-1:0]    sq_y;
    logic [DIST_BITS-1:0]  dist_sq;
    logic                  take_move;
    logic                  take_stable;
    logic [COUNT_BITS-1:0] count_inc;

    // move a beat on when the result register is empty or being drained
    assign advance = in_valid && (!result_valid_reg || !result_stall);

    // squared distance from the held point
    always_comb
    begin
        rx          = COORD_BITS'(in_sample.raw_x);
        ry          = COORD_BITS'(in_sample.raw_y);
        dx          = (rx >= held_x_reg) ? (rx - held_x_reg) : (held_x_reg - rx);
        dy          = (ry >= held_y_reg) ? (ry - held_y_reg) : (held_y_reg - ry);
        sq_x        = SQ_BITS'(dx) * SQ_BITS'(dx);
        sq_y        = SQ_BITS'(dy) * SQ_BITS'(dy);
        dist_sq     = DIST_BITS'(sq_x) + DIST_BITS'(sq_y);
        take_move   = dist_sq > DIST_BITS'(cfg.move_sq);
        take_stable = dist_sq < DIST_BITS'(cfg.stable_sq);
        count_inc   = (stable_count_reg != COUNT_MAX) ? (stable_count_reg + 1'b1)
                                                      : stable_count_reg;
    end

    // next held state
    always_comb
    begin
        held_x_next       = held_x_reg;
        held_y_next       = held_y_reg;
        held_pressed_next = held_pressed_reg;
        held_moving_next  = held_moving_reg;
        stable_count_next = stable_count_reg;
        if (advance)
        begin
            if (!in_sample.touch_present)
            begin
                held_x_next       = '0;
                held_y_next       = '0;
                held_pressed_next = 1'b0;
                held_moving_next  = 1'b0;
                stable_count_next = '0;
            end
            else if (in_sample.point_valid)
            begin
                if (take_move)
                begin
                    held_x_next       = rx;
                    held_y_next       = ry;
                    held_pressed_next = 1'b1;
                    held_moving_next  = 1'b1;
                    stable_count_next = '0;
                end
                else if (take_stable)
                begin
                    stable_count_next = count_inc;
                    if (count_inc >= cfg.confirm)
                    begin
                        held_x_next       = rx;
                        held_y_next       = ry;
                        held_pressed_next = 1'b1;
                        held_moving_next  = 1'b0;
                    end
                end
            end
        end
    end

    // result beat is valid after each advance until drained
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            held_pressed_reg <= 1'b0;
            held_moving_reg  <= 1'b0;
            stable_count_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            held_x_reg       <= held_x_next;
            held_y_reg       <= held_y_next;
            held_pressed_reg <= held_pressed_next;
            held_moving_reg  <= held_moving_next;
            stable_count_reg <= stable_count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // the held state is the published result; it only changes on advance
    assign result_valid  = result_valid_reg;
    assign result.pos_x  = FIELD_BITS'(held_x_reg);
    assign result.pos_y  = FIELD_BITS'(held_y_reg);
    assign result.pressed = held_pressed_reg;
    assign result.moving  = held_moving_reg;

    `TAD_ASSERT_ALWAYS(a_moving_pressed, held_moving_reg |-> held_pressed_reg, "moving without press")
    `TAD_ASSERT_ALWAYS(a_release_origin, !held_pressed_reg |-> (held_x_reg == '0 && held_y_reg == '0), "released point not at origin")
    `TAD_ASSERT(a_release_clear, (advance && !in_sample.touch_present) |=> (!held_pressed_reg && stable_count_reg == '0), "release did not clear state")
    `TAD_ASSERT(a_move_publish, (advance && in_sample.touch_present && in_sample.point_valid && take_move) |=> (held_moving_reg && stable_count_reg == '0), "move bypass not published")
    `TAD_ASSERT(a_hold_on_stall, !advance |=> ($stable(held_x_reg) && $stable(held_y_reg) && $stable(stable_count_reg)), "state changed without advance")

endmodule

[design/touch_adaptive_debounce.sv]
// Path: a sample beat is held in the input register, then the distance test and
// state update load the held-state result register. Throughput: one sample per
// cycle while result_stall is low or the result register is empty.
// Reset (rst_n low, asynchronous): point released at (0,0), count cleared,
// thresholds back to move 30, stable 8, confirm 3; no clearing pass.
// ============================================================================
// Touch debounce top level
// Adaptive debounce of touch samples with a fast-move bypass.
// ============================================================================
module touch_adaptive_debounce #(
    parameter int COORD_BITS = tad_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tad_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tad_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  tad_pkg::sample_t                 sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output tad_pkg::result_t                 result
);
    import tad_pkg::*;

    cfg_t    cfg;
    logic    held_valid;
    sample_t held_sample;
    logic    advance;

    // configuration registers
    tad_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    tad_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .advance      (advance),
        .held_valid   (held_valid),
        .held_sample  (held_sample)
    );

    // distance test, state and result register
    tad_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (held_valid),
        .in_sample    (held_sample),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
